// ===== rtl/core/lookahead_true_peak_limiter_defines.svh =====
// Assertion helpers shared by the limiter RTL.
`ifndef LOOKAHEAD_TRUE_PEAK_LIMITER_DEFINES_SVH
`define LOOKAHEAD_TRUE_PEAK_LIMITER_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LTPL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("limiter assertion failed");

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define LTPL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("limiter assertion failed");

`endif

// ===== rtl/core/ltpl_pkg.sv =====
package ltpl_pkg;

    localparam int MAX_DELAY   = 2048;
    localparam int SAMPLE_BITS = 24;
    localparam int ADDR_W      = $clog2(MAX_DELAY);
    localparam int GAIN_W      = 25;
    localparam int COEF_W      = 24;
    localparam int DLY_W       = 12;
    localparam int FRAC_W      = 24;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 25;
    localparam int PEAK_W      = SAMPLE_BITS + 13;
    localparam int REM_W       = PEAK_W + 1;
    localparam int DIV_STEPS   = SAMPLE_BITS + 11;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
    localparam int MUL_W       = (SAMPLE_BITS > 26) ? SAMPLE_BITS : 26;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int PCOEF_W     = 14;

    localparam logic [GAIN_W-1:0] ONE_Q24  = GAIN_W'(1 << FRAC_W);
    localparam logic [PROD_W-1:0] HALF_Q24 = PROD_W'(1 << (FRAC_W - 1));
    localparam logic [PROD_W-1:0] SAT_HI   =
        PROD_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

    localparam logic [COEF_W-1:0]     RST_ATTACK  = COEF_W'(16568850);
    localparam logic [COEF_W-1:0]     RST_RELEASE = COEF_W'(16774303);
    localparam logic [GAIN_W-1:0]     RST_CEILING = GAIN_W'(14952710);
    localparam logic [DLY_W-1:0]      RST_DELAY   = DLY_W'(240);

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = CFG_IDX_W'(4);

    typedef enum logic [4:0] {
        ST_CLR,
        ST_IDLE,
        ST_X0,
        ST_X1,
        ST_PEAK,
        ST_DIVS,
        ST_DIV,
        ST_ENV,
        ST_APP,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_SL,
        ST_SR,
        ST_SF,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [PCOEF_W-1:0] c0;
        logic signed [PCOEF_W-1:0] c1;
        logic signed [PCOEF_W-1:0] cs;
    } t_pcoef;

    // Weights of the two older samples and the new sample at each quarter point,
    // scaled by 4096.
    function automatic t_pcoef peak_coef(logic [1:0] k);
        t_pcoef c;
        case (k)
            2'd0: c = '{c0: 14'sd0,    c1: 14'sd4096, cs: 14'sd0};
            2'd1: c = '{c0: -14'sd63,  c1: 14'sd3548, cs: 14'sd547};
            2'd2: c = '{c0: -14'sd240, c1: 14'sd2944, cs: 14'sd1136};
            2'd3: c = '{c0: -14'sd513, c1: 14'sd2308, cs: 14'sd1725};
            default: c = '{c0: 14'sd0, c1: 14'sd0, cs: 14'sd0};
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/ltpl_ifs.sv =====
interface ltpl_smp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ltpl_pkg::SAMPLE_BITS-1:0] left_in;
    logic signed [ltpl_pkg::SAMPLE_BITS-1:0] right_in;
    modport source(output valid, left_in, right_in, input ready);
    modport sink(input valid, left_in, right_in, output ready);
endinterface

interface ltpl_res_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [ltpl_pkg::SAMPLE_BITS-1:0] left_out;
    logic signed [ltpl_pkg::SAMPLE_BITS-1:0] right_out;
    logic [ltpl_pkg::GAIN_W-1:0]            gain_now;
    modport source(output valid, left_out, right_out, gain_now, input ready);
    modport sink(input valid, left_out, right_out, gain_now, output ready);
endinterface

interface ltpl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ltpl_pkg::CFG_IDX_W-1:0]  index;
    logic [ltpl_pkg::CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/lookahead_true_peak_limiter.sv =====
// Channel  Dir  Contents                              Transaction
// i_smp    in   left_in, right_in                     valid & ready
// o_res    out  left_out, right_out, gain_now         valid & ready
// i_cfg    in   index, data (register write)          valid & ready, ready always high
//
// With limiting on, a pair holds the block until its result is in the output register.
// The 35-step restoring divider for the needed gain runs only when the peak is above
// the ceiling, and an envelope release adds a pass through the one shared multiplier.
// With limiting off, a pair goes straight to the output state. After reset, and after
// a write that changes the effective delay, the whole history memory is cleared one
// entry a cycle with i_smp not ready. A finished result waits in the output register
// while the next pair is taken.
module lookahead_true_peak_limiter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ltpl_smp_if.sink    i_smp,
    ltpl_res_if.source  o_res,
    ltpl_cfg_if.sink    i_cfg
);
    import ltpl_pkg::*;

    `include "lookahead_true_peak_limiter_defines.svh"

    localparam int SW = SAMPLE_BITS;

    logic [2*SW-1:0] r_mem [MAX_DELAY];
    logic [2*SW-1:0] r_rdata;
    logic            w_we;
    logic            w_re;
    logic [ADDR_W-1:0] w_waddr;
    logic [ADDR_W-1:0] w_raddr;
    logic [2*SW-1:0] w_wdata;

    t_state r_state, n_state;
    logic              r_enable, n_enable;
    logic [GAIN_W-1:0] r_ceil, n_ceil;
    logic [DLY_W-1:0]  r_delay, n_delay;
    logic [COEF_W-1:0] r_att, n_att;
    logic [COEF_W-1:0] r_rel, n_rel;
    logic [ADDR_W-1:0] r_wr_idx, n_wr_idx;
    logic [ADDR_W-1:0] r_clr_idx, n_clr_idx;
    logic [ADDR_W-1:0] r_opos, n_opos;
    logic [GAIN_W-1:0] r_env, n_env;
    logic [GAIN_W-1:0] r_applied, n_applied;
    logic signed [SW-1:0] r_l, n_l;
    logic signed [SW-1:0] r_r, n_r;
    logic [2*SW-1:0]   r_x0, n_x0;
    logic [2*SW-1:0]   r_x1, n_x1;
    logic [2:0]        r_step, n_step;
    logic [PEAK_W-1:0] r_pk, n_pk;
    logic [PEAK_W-1:0] r_rem, n_rem;
    logic [GAIN_W-1:0] r_q, n_q;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [GAIN_W-1:0] r_need, n_need;
    logic [COEF_W-1:0] r_c, n_c;
    logic [GAIN_W-1:0] r_old, n_old;
    logic [GAIN_W-1:0] r_new, n_new;
    logic              r_mop, n_mop;
    logic              r_floor, n_floor;
    logic signed [PROD_W-1:0] r_prod, n_prod;
    logic signed [PROD_W-1:0] r_acc, n_acc;
    logic signed [SW-1:0] r_lo, n_lo;
    logic signed [SW-1:0] r_ro, n_ro;
    logic              r_ovalid, n_ovalid;
    logic signed [SW-1:0] r_o_l, n_o_l;
    logic signed [SW-1:0] r_o_r, n_o_r;
    logic [GAIN_W-1:0] r_o_g, n_o_g;

    logic signed [MUL_W-1:0]  w_mul_a;
    logic signed [MUL_W-1:0]  w_mul_b;
    logic signed [PROD_W-1:0] w_mul_p;

    t_pcoef              w_pc;
    logic signed [SW-1:0] w_px0;
    logic signed [SW-1:0] w_px1;
    logic signed [SW-1:0] w_ps;
    logic signed [PEAK_W-1:0] w_v;
    logic [PEAK_W-1:0]   w_vm;
    logic [REM_W-1:0]    w_rem2;
    logic [PROD_W-1:0]   w_sum;
    logic [GAIN_W-1:0]   w_res;
    logic [PEAK_W+GAIN_W-1:0] w_thr;
    logic [ADDR_W:0]     w_d;

    function automatic logic [ADDR_W:0] eff_dly(logic [DLY_W-1:0] raw);
        logic [ADDR_W:0] d;
        if (raw == '0) begin
            d = (ADDR_W+1)'(1);
        end else if (32'(raw) > MAX_DELAY) begin
            d = (ADDR_W+1)'(MAX_DELAY);
        end else begin
            d = (ADDR_W+1)'(raw);
        end
        return d;
    endfunction

    function automatic logic [ADDR_W-1:0] back(logic [ADDR_W-1:0] p, logic [ADDR_W:0] d);
        logic [ADDR_W:0] s;
        if ({1'b0, p} >= d) begin
            s = {1'b0, p} - d;
        end else begin
            s = {1'b0, p} + (ADDR_W+1)'(MAX_DELAY) - d;
        end
        return s[ADDR_W-1:0];
    endfunction

    function automatic logic signed [SW-1:0] round_sat(logic signed [PROD_W-1:0] prod);
        logic [PROD_W-1:0] m;
        logic [PROD_W-1:0] q;
        logic [PROD_W-1:0] r;
        m = prod[PROD_W-1] ? PROD_W'(-prod) : PROD_W'(prod);
        q = (m + HALF_Q24) >> FRAC_W;
        if (!prod[PROD_W-1]) begin
            r = (q > SAT_HI) ? SAT_HI : q;
        end else begin
            r = (q > SAT_HI + PROD_W'(1)) ? PROD_W'(-(SAT_HI + PROD_W'(1))) : PROD_W'(-q);
        end
        return SW'(r);
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    always_comb begin
        w_pc  = peak_coef(r_step[1:0]);
        w_px0 = r_step[2] ? $signed(r_x0[SW-1:0]) : $signed(r_x0[2*SW-1:SW]);
        w_px1 = r_step[2] ? $signed(r_x1[SW-1:0]) : $signed(r_x1[2*SW-1:SW]);
        w_ps  = r_step[2] ? r_r : r_l;
        w_v   = PEAK_W'(w_px0) * PEAK_W'(w_pc.c0)
              + PEAK_W'(w_px1) * PEAK_W'(w_pc.c1)
              + PEAK_W'(w_ps) * PEAK_W'(w_pc.cs);
        w_vm  = w_v[PEAK_W-1] ? PEAK_W'(-w_v) : PEAK_W'(w_v);
        w_thr = (PEAK_W+GAIN_W)'(r_ceil) << (SAMPLE_BITS - 13);
        w_rem2 = {r_rem, 1'b0};
        w_sum = PROD_W'(r_acc) + PROD_W'(r_prod) + HALF_Q24;
        w_res = GAIN_W'(w_sum >> FRAC_W);
        w_d   = eff_dly(r_delay);
    end

    assign i_smp.ready   = (r_state == ST_IDLE);
    assign i_cfg.ready   = 1'b1;
    assign o_res.valid   = r_ovalid;
    assign o_res.left_out  = r_o_l;
    assign o_res.right_out = r_o_r;
    assign o_res.gain_now  = r_o_g;

    always_comb begin
        n_state = r_state;
        n_enable = r_enable;
        n_ceil = r_ceil;
        n_delay = r_delay;
        n_att = r_att;
        n_rel = r_rel;
        n_wr_idx = r_wr_idx;
        n_clr_idx = r_clr_idx;
        n_opos = r_opos;
        n_env = r_env;
        n_applied = r_applied;
        n_l = r_l;
        n_r = r_r;
        n_x0 = r_x0;
        n_x1 = r_x1;
        n_step = r_step;
        n_pk = r_pk;
        n_rem = r_rem;
        n_q = r_q;
        n_cnt = r_cnt;
        n_need = r_need;
        n_c = r_c;
        n_old = r_old;
        n_new = r_new;
        n_mop = r_mop;
        n_floor = r_floor;
        n_prod = r_prod;
        n_acc = r_acc;
        n_lo = r_lo;
        n_ro = r_ro;
        n_ovalid = r_ovalid;
        n_o_l = r_o_l;
        n_o_r = r_o_r;
        n_o_g = r_o_g;
        w_we = 1'b0;
        w_re = 1'b0;
        w_waddr = r_wr_idx;
        w_raddr = r_wr_idx;
        w_wdata = '0;
        w_mul_a = '0;
        w_mul_b = '0;

        if (r_ovalid && o_res.ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_CLR: begin
                w_we = 1'b1;
                w_waddr = r_clr_idx;
                if (r_clr_idx == ADDR_W'(MAX_DELAY - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (i_smp.valid) begin
                    n_l = i_smp.left_in;
                    n_r = i_smp.right_in;
                    if (!r_enable) begin
                        n_lo = i_smp.left_in;
                        n_ro = i_smp.right_in;
                        n_state = ST_OUT;
                    end else begin
                        w_re = 1'b1;
                        w_raddr = back(r_wr_idx, (ADDR_W+1)'(2));
                        n_state = ST_X0;
                    end
                end
            end
            ST_X0: begin
                n_x0 = r_rdata;
                w_re = 1'b1;
                w_raddr = back(r_wr_idx, (ADDR_W+1)'(1));
                n_state = ST_X1;
            end
            ST_X1: begin
                n_x1 = r_rdata;
                w_we = 1'b1;
                w_wdata = {r_l, r_r};
                n_opos = back(r_wr_idx, w_d);
                n_wr_idx = (r_wr_idx == ADDR_W'(MAX_DELAY - 1)) ? '0 : r_wr_idx + ADDR_W'(1);
                n_step = '0;
                n_pk = '0;
                n_state = ST_PEAK;
            end
            ST_PEAK: begin
                if (w_vm > r_pk) begin
                    n_pk = w_vm;
                end
                n_step = r_step + 3'd1;
                if (r_step == 3'd7) begin
                    n_state = ST_DIVS;
                end
            end
            ST_DIVS: begin
                if ((PEAK_W+GAIN_W)'(r_pk) > w_thr) begin
                    n_rem = PEAK_W'(r_ceil);
                    n_q = '0;
                    n_cnt = '0;
                    n_state = ST_DIV;
                end else begin
                    n_need = ONE_Q24;
                    n_state = ST_ENV;
                end
            end
            ST_DIV: begin
                if (w_rem2 >= REM_W'(r_pk)) begin
                    n_rem = PEAK_W'(w_rem2 - REM_W'(r_pk));
                    n_q = {r_q[GAIN_W-2:0], 1'b1};
                end else begin
                    n_rem = w_rem2[PEAK_W-1:0];
                    n_q = {r_q[GAIN_W-2:0], 1'b0};
                end
                n_cnt = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_need = n_q;
                    n_state = ST_ENV;
                end
            end
            ST_ENV: begin
                if (r_need < r_env) begin
                    n_env = r_need;
                    n_state = ST_APP;
                end else begin
                    n_c = r_rel;
                    n_old = r_env;
                    n_new = r_need;
                    n_mop = 1'b0;
                    n_state = ST_M1;
                end
            end
            ST_APP: begin
                w_re = 1'b1;
                w_raddr = r_opos;
                n_floor = (r_env < r_applied);
                n_c = (r_env < r_applied) ? r_att : r_rel;
                n_old = r_applied;
                n_new = r_env;
                n_mop = 1'b1;
                n_state = ST_M1;
            end
            ST_M1: begin
                w_mul_a = MUL_W'(r_c);
                w_mul_b = MUL_W'(r_old);
                n_prod = w_mul_p;
                n_state = ST_M2;
            end
            ST_M2: begin
                w_mul_a = MUL_W'(ONE_Q24 - GAIN_W'(r_c));
                w_mul_b = MUL_W'(r_new);
                n_prod = w_mul_p;
                n_acc = r_prod;
                n_state = ST_M3;
            end
            ST_M3: begin
                if (!r_mop) begin
                    n_env = w_res;
                    n_state = ST_APP;
                end else begin
                    n_applied = (r_floor && (w_res < r_new)) ? r_new : w_res;
                    n_state = ST_SL;
                end
            end
            ST_SL: begin
                w_mul_a = MUL_W'($signed(r_rdata[2*SW-1:SW]));
                w_mul_b = MUL_W'(r_applied);
                n_prod = w_mul_p;
                n_state = ST_SR;
            end
            ST_SR: begin
                n_lo = round_sat(r_prod);
                w_mul_a = MUL_W'($signed(r_rdata[SW-1:0]));
                w_mul_b = MUL_W'(r_applied);
                n_prod = w_mul_p;
                n_state = ST_SF;
            end
            ST_SF: begin
                n_ro = round_sat(r_prod);
                n_state = ST_OUT;
            end
            ST_OUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_o_l = r_lo;
                    n_o_r = r_ro;
                    n_o_g = r_applied;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_ENABLE: n_enable = i_cfg.data[0];
                CFG_CEILING: n_ceil = i_cfg.data[GAIN_W-1:0];
                CFG_DELAY: begin
                    n_delay = i_cfg.data[DLY_W-1:0];
                    if (eff_dly(i_cfg.data[DLY_W-1:0]) != w_d) begin
                        n_state = ST_CLR;
                        n_clr_idx = '0;
                        n_wr_idx = '0;
                        n_env = ONE_Q24;
                        n_applied = ONE_Q24;
                    end
                end
                CFG_ATTACK: n_att = i_cfg.data[COEF_W-1:0];
                CFG_RELEASE: n_rel = i_cfg.data[COEF_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_enable <= 1'b0;
            r_ceil <= RST_CEILING;
            r_delay <= RST_DELAY;
            r_att <= RST_ATTACK;
            r_rel <= RST_RELEASE;
            r_wr_idx <= '0;
            r_clr_idx <= '0;
            r_env <= ONE_Q24;
            r_applied <= ONE_Q24;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_enable <= n_enable;
            r_ceil <= n_ceil;
            r_delay <= n_delay;
            r_att <= n_att;
            r_rel <= n_rel;
            r_wr_idx <= n_wr_idx;
            r_clr_idx <= n_clr_idx;
            r_env <= n_env;
            r_applied <= n_applied;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_opos <= n_opos;
        r_l <= n_l;
        r_r <= n_r;
        r_x0 <= n_x0;
        r_x1 <= n_x1;
        r_step <= n_step;
        r_pk <= n_pk;
        r_rem <= n_rem;
        r_q <= n_q;
        r_cnt <= n_cnt;
        r_need <= n_need;
        r_c <= n_c;
        r_old <= n_old;
        r_new <= n_new;
        r_mop <= n_mop;
        r_floor <= n_floor;
        r_prod <= n_prod;
        r_acc <= n_acc;
        r_lo <= n_lo;
        r_ro <= n_ro;
        r_o_l <= n_o_l;
        r_o_r <= n_o_r;
        r_o_g <= n_o_g;
    end

    `LTPL_ASSERT_NXT(a_start_read, i_smp.valid && i_smp.ready && r_enable && !i_cfg.valid, r_state == ST_X0)
    `LTPL_ASSERT_IMP(a_gain_max, r_state == ST_IDLE, r_applied <= ONE_Q24 && r_env <= ONE_Q24)
    `LTPL_ASSERT_NXT(a_res_hold, o_res.valid && !o_res.ready, o_res.valid)
    `LTPL_ASSERT_IMP(a_rem_below, r_state == ST_DIV, r_rem < r_pk)

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import ltpl_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;
    localparam longint UNITY = 64'sd16777216;
    localparam longint ROUND_HALF = 64'sd8388608;

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] left;
        logic signed [SAMPLE_BITS-1:0] right;
        logic [GAIN_W-1:0]             gain;
    } t_frame;

    logic i_clk;
    logic i_rst_n;

    ltpl_smp_if smp();
    ltpl_res_if res();
    ltpl_cfg_if cfg();

    lookahead_true_peak_limiter DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    t_frame expected_frames[$];
    int     error_count;
    int     cycle_count;
    bit     steady_flow;
    int     stall_left;

    bit                   lim_enable;
    logic [GAIN_W-1:0]    lim_ceiling;
    logic [DLY_W-1:0]     lim_delay;
    logic [COEF_W-1:0]    lim_attack;
    logic [COEF_W-1:0]    lim_release;
    logic signed [SAMPLE_BITS-1:0] hist_left[MAX_DELAY];
    logic signed [SAMPLE_BITS-1:0] hist_right[MAX_DELAY];
    int                   wr_pos;
    longint               env_gain;
    longint               app_gain;

    function automatic int clamp_delay(logic [DLY_W-1:0] raw);
        if (raw < 1) return 1;
        if (raw > MAX_DELAY) return MAX_DELAY;
        return int'(raw);
    endfunction

    function automatic void clear_history();
        for (int i = 0; i < MAX_DELAY; i++) begin
            hist_left[i] = '0;
            hist_right[i] = '0;
        end
        wr_pos = 0;
        env_gain = UNITY;
        app_gain = UNITY;
    endfunction

    function automatic longint abs64(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint interp_peak(longint x0, longint x1, longint x2, longint x3);
        longint a0, a1, a2, c1, c2, v, p;
        a0 = -3 * x0 + 9 * x1 + 9 * x2 - 3 * x3;
        a1 = x2 - x1;
        a2 = 3 * x0 - 12 * x1 + 12 * x2 - 3 * x3;
        c1 = 8 * a0 - 3 * a2 - 128 * x1;
        c2 = a2 - 16 * a1;
        p = abs64(4096 * x1);
        for (longint k = 1; k <= 3; k++) begin
            v = c2 * k * k * k + 2 * c1 * k * k + 512 * a1 * k + 4096 * x1;
            if (abs64(v) > p) p = abs64(v);
        end
        return p;
    endfunction

    function automatic longint smooth(logic [COEF_W-1:0] c, longint prev, longint next);
        longint ci;
        ci = longint'({40'd0, c});
        return (ci * prev + (UNITY - ci) * next + ROUND_HALF) >>> 24;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] apply_gain(longint s, longint g);
        longint prod, q;
        prod = s * g;
        q = (abs64(prod) + ROUND_HALF) >>> 24;
        if (prod < 0) q = -q;
        if (q > 8388607) q = 8388607;
        if (q < -8388608) q = -8388608;
        return q[SAMPLE_BITS-1:0];
    endfunction

    function automatic t_frame limiter_step(logic signed [SAMPLE_BITS-1:0] l,
                                            logic signed [SAMPLE_BITS-1:0] r);
        t_frame f;
        int p, im1, im2, opos;
        longint pk, pr, need;
        longint unsigned rem, q, den;
        if (!lim_enable) begin
            f.left = l;
            f.right = r;
            f.gain = app_gain[GAIN_W-1:0];
            return f;
        end
        p = wr_pos;
        im1 = (p + MAX_DELAY - 1) % MAX_DELAY;
        im2 = (p + MAX_DELAY - 2) % MAX_DELAY;
        pk = interp_peak(longint'(hist_left[im2]), longint'(hist_left[im1]),
                         longint'(l), longint'(l));
        pr = interp_peak(longint'(hist_right[im2]), longint'(hist_right[im1]),
                         longint'(r), longint'(r));
        if (pr > pk) pk = pr;
        hist_left[p] = l;
        hist_right[p] = r;
        need = UNITY;
        if (longint'(pk) > (longint'({39'd0, lim_ceiling}) <<< 11)) begin
            rem = {39'd0, lim_ceiling};
            q = 0;
            den = pk;
            for (int i = 0; i < SAMPLE_BITS + 11; i++) begin
                rem = rem << 1;
                q = q << 1;
                if (rem >= den) begin
                    rem = rem - den;
                    q = q | 1;
                end
            end
            need = longint'(q);
        end
        if (need < env_gain) env_gain = need;
        else env_gain = smooth(lim_release, env_gain, need);
        if (env_gain < app_gain) begin
            app_gain = smooth(lim_attack, app_gain, env_gain);
            if (app_gain < env_gain) app_gain = env_gain;
        end else begin
            app_gain = smooth(lim_release, app_gain, env_gain);
        end
        opos = (p + MAX_DELAY - clamp_delay(lim_delay)) % MAX_DELAY;
        f.left = apply_gain(longint'(hist_left[opos]), app_gain);
        f.right = apply_gain(longint'(hist_right[opos]), app_gain);
        f.gain = app_gain[GAIN_W-1:0];
        wr_pos = (p + 1) % MAX_DELAY;
        return f;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res.valid && res.ready) begin
            if (expected_frames.size() == 0) begin
                $display("%0t: unexpected result %0d %0d %0d", $time,
                         res.left_out, res.right_out, res.gain_now);
                error_count++;
            end else begin
                t_frame e;
                e = expected_frames.pop_front();
                if (res.left_out !== e.left) begin
                    $display("%0t: left_out expected %0d actual %0d", $time, e.left,
                             res.left_out);
                    error_count++;
                end
                if (res.right_out !== e.right) begin
                    $display("%0t: right_out expected %0d actual %0d", $time, e.right,
                             res.right_out);
                    error_count++;
                end
                if (res.gain_now !== e.gain) begin
                    $display("%0t: gain_now expected %0d actual %0d", $time, e.gain,
                             res.gain_now);
                    error_count++;
                end
            end
        end
        if (steady_flow) begin
            res.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res.ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 5);
            res.ready <= 1'b0;
        end else begin
            res.ready <= 1'b1;
        end
    end

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] l,
                               logic signed [SAMPLE_BITS-1:0] r);
        if (!steady_flow && $urandom_range(0, 4) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.left_in <= l;
        smp.right_in <= r;
        do @(posedge i_clk); while (!smp.ready);
        expected_frames.push_back(limiter_step(l, r));
    endtask

    task automatic drain();
        smp.valid <= 1'b0;
        do @(posedge i_clk); while (expected_frames.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        int old_delay;
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge i_clk); while (!cfg.ready);
        cfg.valid <= 1'b0;
        case (idx)
            CFG_ENABLE:  lim_enable = value[0];
            CFG_CEILING: lim_ceiling = value[GAIN_W-1:0];
            CFG_DELAY: begin
                old_delay = clamp_delay(lim_delay);
                if (clamp_delay(value[DLY_W-1:0]) != old_delay) clear_history();
                lim_delay = value[DLY_W-1:0];
            end
            CFG_ATTACK:  lim_attack = value[COEF_W-1:0];
            CFG_RELEASE: lim_release = value[COEF_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_limiter(bit en, int ceil_v, int dly, int att, int rel);
        drain();
        write_reg(CFG_ENABLE, CFG_DATA_W'(en));
        write_reg(CFG_CEILING, CFG_DATA_W'(ceil_v));
        write_reg(CFG_DELAY, CFG_DATA_W'(dly));
        write_reg(CFG_ATTACK, CFG_DATA_W'(att));
        write_reg(CFG_RELEASE, CFG_DATA_W'(rel));
    endtask

    task automatic test_passthrough();
        send_sample(24'sh7FFFFF, -24'sh800000);
        send_sample(-24'sh800000, 24'sh7FFFFF);
        send_sample(24'sh000000, 24'sh000001);
        send_sample(24'sh555555, -24'sh2AAAAB);
    endtask

    task automatic test_overshoot();
        set_limiter(1, 14952710, 1, 16568850, 16774303);
        send_sample(0, 0);
        send_sample(0, 0);
        send_sample(24'sh7FFFFF, 24'sh7FFFFF);
        send_sample(-24'sh800000, -24'sh800000);
        send_sample(24'sh7FFFFF, 0);
        send_sample(-24'sh800000, 24'sh7FFFFF);
        send_sample(0, -24'sh800000);
    endtask

    task automatic test_delay_edges();
        set_limiter(1, 16777216, 0, 0, 16777215);
        send_sample(24'sh400000, -24'sh400000);
        send_sample(24'sh7FFFFF, 24'sh100000);
        set_limiter(1, 8408523, 4095, 16777215, 0);
        send_sample(24'sh7FFFFF, -24'sh800000);
        send_sample(24'sh123456, -24'sh654321);
        send_sample(-24'sh7FFFFF, 24'sh7FFFFF);
    endtask

    task automatic test_ceiling_edges();
        set_limiter(1, 0, 3, 8000000, 16000000);
        send_sample(0, 0);
        send_sample(24'sh000001, 0);
        send_sample(24'sh7FFFFF, -24'sh000001);
        set_limiter(1, 33554431, 3, 8000000, 16000000);
        send_sample(24'sh7FFFFF, -24'sh800000);
        send_sample(-24'sh800000, 24'sh7FFFFF);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(int shape,
            logic signed [SAMPLE_BITS-1:0] prev);
        case (shape)
            0: return SAMPLE_BITS'($urandom());
            1: return prev + $signed(24'($urandom_range(0, 2097151)) - 24'sh100000);
            2: return $urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000;
            default: return $signed(24'($urandom_range(0, 8191))) - 24'sh001000;
        endcase
    endfunction

    task automatic test_random();
        logic signed [SAMPLE_BITS-1:0] l, r;
        int dly, shape;
        l = 0;
        r = 0;
        for (int phase = 0; phase < 20; phase++) begin
            case ($urandom_range(0, 5))
                0: dly = $urandom_range(1, 4095);
                default: dly = $urandom_range(1, 40);
            endcase
            if (phase == 18) steady_flow = 1'b1;
            set_limiter($urandom_range(0, 7) != 0,
                        $urandom_range(8408523, 16777216), dly,
                        $urandom_range(0, 3) == 0 ? $urandom_range(0, 16777215)
                                                  : $urandom_range(16000000, 16777215),
                        $urandom_range(0, 3) == 0 ? $urandom_range(0, 16777215)
                                                  : $urandom_range(16600000, 16777215));
            shape = $urandom_range(0, 3);
            for (int n = 0; n < 100; n++) begin
                if (n == 50 && phase == 5) drain();
                if ($urandom_range(0, 9) == 0) shape = $urandom_range(0, 3);
                l = pick_sample(shape, l);
                r = pick_sample(shape, r);
                send_sample(l, r);
            end
        end
    endtask

    initial begin
        steady_flow = 1'b0;
        lim_enable = 1'b0;
        lim_ceiling = RST_CEILING;
        lim_delay = RST_DELAY;
        lim_attack = RST_ATTACK;
        lim_release = RST_RELEASE;
        clear_history();
        i_rst_n <= 1'b0;
        smp.valid <= 1'b0;
        smp.left_in <= '0;
        smp.right_in <= '0;
        cfg.valid <= 1'b0;
        cfg.index <= '0;
        cfg.data <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_passthrough();
        test_overshoot();
        test_delay_edges();
        test_ceiling_edges();
        test_random();
        drain();
        repeat (80) @(posedge i_clk);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/ltpl_pkg.sv
rtl/core/ltpl_ifs.sv
rtl/core/lookahead_true_peak_limiter.sv
bench/testbench.sv
